[design/kdar_pkg.sv]
package kdar_pkg;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_PRESS_CHK   = 3'd1,
		PH_HOLD        = 3'd2,
		PH_REPEAT      = 3'd3,
		PH_REL_HOLD    = 3'd4,
		PH_REL_REPEAT  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_REPEAT  = 2'd2,
		EV_RELEASE = 2'd3
	} key_event_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

	localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;
	localparam logic [15:0] HOLD_RESET     = 16'd500;
	localparam logic [15:0] REPEAT_RESET   = 16'd1;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] hold_ticks;
		logic [15:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] key_flags;
		key_event_t key_event;
		logic       beep_request;
	} result_t;

endpackage

[design/kdar_core.sv]
module kdar_core
	import kdar_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] key_levels,
	input  logic       beep_allowed,
	input  cfg_t       cfg,
	output result_t    result
);

	phase_t      phase_q, phase_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  latched_q, latched_d;

	logic [7:0]  pressed;
	logic        any_down;
	logic        expire;
	logic [15:0] debounce_load;
	logic [15:0] hold_load;
	logic [15:0] repeat_load;
	logic [15:0] wait_dec;
	key_event_t  event_d;
	logic        beep_d;

	assign pressed  = ~key_levels;
	assign any_down = |pressed;
	assign expire   = (wait_q <= 16'd1);
	assign wait_dec = expire ? 16'd0 : (wait_q - 16'd1);

	assign debounce_load = (cfg.debounce_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.debounce_ticks};
	assign hold_load     = (cfg.hold_ticks == 16'd0) ? 16'd1 : cfg.hold_ticks;
	assign repeat_load   = (cfg.repeat_ticks == 16'd0) ? 16'd1 : cfg.repeat_ticks;

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		latched_d = latched_q;
		case (phase_q)
			PH_PRESS_CHK: begin
				wait_d = wait_dec;
				if (expire) begin
					if (any_down) begin
						latched_d = latched_q | pressed;
						phase_d   = PH_HOLD;
						wait_d    = hold_load;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_HOLD, PH_REPEAT: begin
				if (any_down) begin
					wait_d = wait_dec;
					if (expire) begin
						latched_d = latched_q | pressed;
						phase_d   = PH_REPEAT;
						wait_d    = repeat_load;
					end
				end else begin
					phase_d = (phase_q == PH_HOLD) ? PH_REL_HOLD : PH_REL_REPEAT;
					wait_d  = debounce_load;
				end
			end
			PH_REL_HOLD, PH_REL_REPEAT: begin
				wait_d = wait_dec;
				if (expire) begin
					if (!any_down) begin
						latched_d = 8'd0;
						phase_d   = PH_IDLE;
					end else if (phase_q == PH_REL_HOLD) begin
						phase_d = PH_HOLD;
						wait_d  = hold_load;
					end else begin
						phase_d = PH_REPEAT;
						wait_d  = repeat_load;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (any_down) begin
					phase_d = PH_PRESS_CHK;
					wait_d  = debounce_load;
				end
			end
		endcase
	end

	always_comb begin
		event_d = EV_NONE;
		beep_d  = 1'b0;
		case (phase_q)
			PH_PRESS_CHK: begin
				if (expire && any_down) begin
					event_d = EV_PRESS;
					beep_d  = beep_allowed;
				end
			end
			PH_HOLD, PH_REPEAT: begin
				if (any_down && expire) begin
					event_d = EV_REPEAT;
					beep_d  = beep_allowed;
				end
			end
			PH_REL_HOLD, PH_REL_REPEAT: begin
				if (expire && !any_down) begin
					event_d = EV_RELEASE;
				end
			end
			default: begin
				event_d = EV_NONE;
			end
		endcase
	end

	assign result.key_flags    = latched_d;
	assign result.key_event    = event_d;
	assign result.beep_request = beep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			wait_q    <= 16'd0;
			latched_q <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			latched_q <= latched_d;
		end
	end

endmodule

[design/key_debounce_auto_repeat.sv]
// Eight-key debounce with auto-repeat. Each request is one tick: the eight
// active-low key levels and a beep-allowed flag; each request yields exactly
// one result with the latched key flags, the event of that tick (none, press,
// repeat, release) and a beep request. The block takes one request every
// cycle while the output is not stalled; a request passes an input register
// and then a result register before its result is presented at the output.
// The debounce, hold and repeat times count requests, not clock cycles. The
// user writes them through the cfg port (index 0 debounce, 1 hold, 2 repeat;
// other indexes are ignored) only while no request is in flight; the block
// itself does not enforce this.
module key_debounce_auto_repeat
	import kdar_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            key_levels,
	input  logic                  beep_allowed,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            key_flags,
	output logic [1:0]            key_event,
	output logic                  beep_request,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] key_levels_s1;
	logic       beep_allowed_s1;
	logic       out_valid_q;
	result_t    result_q;
	result_t    result;
	logic       out_adv;
	logic       in_take;
	logic       step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.hold_ticks     <= HOLD_RESET;
			cfg_q.repeat_ticks   <= REPEAT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data[7:0];
				REG_HOLD:     cfg_q.hold_ticks     <= cfg_data;
				REG_REPEAT:   cfg_q.repeat_ticks   <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_adv  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_adv;
	assign in_stall = valid_s1 && !out_adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (out_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			key_levels_s1   <= key_levels;
			beep_allowed_s1 <= beep_allowed;
		end
	end

	kdar_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.key_levels   (key_levels_s1),
		.beep_allowed (beep_allowed_s1),
		.cfg          (cfg_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_flags    = result_q.key_flags;
	assign key_event    = result_q.key_event;
	assign beep_request = result_q.beep_request;

endmodule
